>>> hw/rtl/key_matrix_change_detector_core_assert.svh
// assertion macros shared by the key matrix change detector rtl
// both expect clk and rst_n in scope
`ifndef KEY_MATRIX_CHANGE_DETECTOR_CORE_ASSERT_SVH
`define KEY_MATRIX_CHANGE_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define KMCD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/kmcd_pkg.sv
package kmcd_pkg;

  localparam int MAX_COLS = 16;
  localparam int MAX_ROWS = 8;

  // payload widths
  localparam int COL_FIELD_W = 16;
  localparam int ROW_IDX_IN_W = 3;
  localparam int EVENT_W = 9;

  // config register widths
  localparam int COL_CNT_W = 5;
  localparam int ROW_CNT_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam int EFF_COLS_MAX = (MAX_COLS < COL_FIELD_W) ? MAX_COLS : COL_FIELD_W;
  localparam int ROW_SEL_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_SEL_W = $clog2(COL_FIELD_W);

  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } kmcd_state_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } kmcd_cmd_t;

  typedef struct packed {
    logic diff_empty;
    logic last_pending;
    logic out_free;
  } kmcd_sts_t;

endpackage

>>> hw/rtl/key_matrix_change_detector_core.sv
// key matrix change detector
// input channel (in_valid / in_stall): one request per scanned row, carrying
//   in_row_index and in_column_levels (bit c low = key pressed)
// output channel (out_valid / out_stall): one request per key whose level
//   changed, in column order; out_key_event is +key number on press and
//   -key number on release (key number = row * columns + column + 1),
//   out_last_event marks the final event of a row sample
// config channel (cfg_valid / cfg_ready): index 0 columns in use,
//   index 1 rows in use; cfg_ready is always high, write only while idle
// the change mask is registered when a row is taken; its events are then
//   loaded into the output register from the emit state, one changed column
//   per cycle while the output slot is free
// reset: every key released, 16 columns and 8 rows in use, nothing pending
// a stalled output holds its event; the scan waits until the slot frees,
//   and a new row is taken once the last event sits in the output register
// rows at or beyond rows in use are taken and dropped without events
module key_matrix_change_detector_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // row sample input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [kmcd_pkg::ROW_IDX_IN_W-1:0]      in_row_index,
  input  logic [kmcd_pkg::COL_FIELD_W-1:0]       in_column_levels,
  // key events
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [kmcd_pkg::EVENT_W-1:0]    out_key_event,
  output logic                                   out_last_event,
  // register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [kmcd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kmcd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import kmcd_pkg::*;

  kmcd_cmd_t cmd;
  kmcd_sts_t sts;

  // register writes never back-pressure
  assign cfg_ready = 1'b1;

  // sequencer: idle / emit
  kmcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // key level store, change mask, event builder and output register
  kmcd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_row_index     (in_row_index),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_event    (out_key_event),
    .out_last_event   (out_last_event)
  );

endmodule

>>> hw/rtl/kmcd_ctrl.sv
module kmcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output kmcd_pkg::kmcd_cmd_t cmd,
  input  kmcd_pkg::kmcd_sts_t sts
);
  import kmcd_pkg::*;

  `include "key_matrix_change_detector_core_assert.svh"

  kmcd_state_t state_r;
  kmcd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        priority if (sts.diff_empty) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free && sts.last_pending) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EMIT: begin
        cmd.load_out = !sts.diff_empty && sts.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  `KMCD_ASSERT_NEXT(a_accept_to_emit, cmd.accept, state_r == ST_EMIT,
                    "accepted request did not start emitting")
  `KMCD_ASSERT_NOW(a_load_needs_slot, cmd.load_out, sts.out_free && !in_stall == 1'b0,
                   "event loaded into a busy output slot")

endmodule

>>> hw/rtl/kmcd_dp.sv
module kmcd_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  kmcd_pkg::kmcd_cmd_t                    cmd,
  output kmcd_pkg::kmcd_sts_t                    sts,
  input  logic                                   cfg_valid,
  input  logic [kmcd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kmcd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [kmcd_pkg::ROW_IDX_IN_W-1:0]      in_row_index,
  input  logic [kmcd_pkg::COL_FIELD_W-1:0]       in_column_levels,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [kmcd_pkg::EVENT_W-1:0]    out_key_event,
  output logic                                   out_last_event
);
  import kmcd_pkg::*;

  `include "key_matrix_change_detector_core_assert.svh"

  logic [COL_CNT_W-1:0]   cols_r;
  logic [ROW_CNT_W-1:0]   rows_r;
  logic [COL_FIELD_W-1:0] levels_mem_r [MAX_ROWS];

  logic [COL_FIELD_W-1:0] diff_r;
  logic [COL_FIELD_W-1:0] levels_r;
  logic [EVENT_W-1:0]     base_r;

  logic                   out_valid_r;
  logic [EVENT_W-1:0]     event_r;
  logic                   last_r;

  logic [COL_CNT_W-1:0]   ncols;
  logic [ROW_CNT_W:0]     nrows;
  logic                   row_ok;
  logic [ROW_SEL_W-1:0]   row_sel;
  logic [COL_FIELD_W-1:0] col_mask;
  logic [COL_FIELD_W-1:0] stored;
  logic [COL_FIELD_W-1:0] low_bit;
  logic [COL_FIELD_W-1:0] diff_rest;
  logic [COL_SEL_W-1:0]   col_idx;
  logic [EVENT_W-1:0]     key_num;
  logic                   released;

  // saturated counts and active column mask
  always_comb begin
    priority if (cols_r == '0) begin
      ncols = COL_CNT_W'(1);
    end else if (int'(cols_r) > EFF_COLS_MAX) begin
      ncols = COL_CNT_W'(EFF_COLS_MAX);
    end else begin
      ncols = cols_r;
    end
    priority if (rows_r == '0) begin
      nrows = (ROW_CNT_W+1)'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      nrows = (ROW_CNT_W+1)'(MAX_ROWS);
    end else begin
      nrows = {1'b0, rows_r};
    end
    for (int i = 0; i < COL_FIELD_W; i++) begin
      col_mask[i] = (i < EFF_COLS_MAX) && (int'(ncols) > i);
    end
  end

  assign row_ok  = (ROW_CNT_W+1)'(in_row_index) < nrows;
  assign row_sel = ROW_SEL_W'(in_row_index);
  assign stored  = levels_mem_r[row_sel];

  // lowest pending column
  always_comb begin
    low_bit   = diff_r & (~diff_r + COL_FIELD_W'(1));
    diff_rest = diff_r & (diff_r - COL_FIELD_W'(1));
    col_idx   = '0;
    for (int i = 0; i < COL_FIELD_W; i++) begin
      if (low_bit[i]) begin
        col_idx = col_idx | COL_SEL_W'(i);
      end
    end
    released = |(low_bit & levels_r);
    key_num  = base_r + EVENT_W'(col_idx) + EVENT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COL_CNT_W'(16);
      rows_r <= ROW_CNT_W'(8);
      for (int r = 0; r < MAX_ROWS; r++) begin
        levels_mem_r[r] <= '1;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_COLS_IN_USE: cols_r <= cfg_data[COL_CNT_W-1:0];
          CFG_ROWS_IN_USE: rows_r <= cfg_data[ROW_CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept && row_ok) begin
        levels_mem_r[row_sel] <= (stored & ~col_mask) | (in_column_levels & col_mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r <= '0;
    end else if (cmd.accept) begin
      diff_r <= row_ok ? ((in_column_levels ^ stored) & col_mask) : '0;
    end else if (cmd.load_out) begin
      diff_r <= diff_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      levels_r <= in_column_levels;
      base_r   <= EVENT_W'(in_row_index) * EVENT_W'(ncols);
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      event_r <= released ? (EVENT_W'(0) - key_num) : key_num;
      last_r  <= (diff_rest == '0);
    end
  end

  assign sts.diff_empty   = (diff_r == '0);
  assign sts.last_pending = (diff_rest == '0);
  assign sts.out_free     = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_key_event  = signed'(event_r);
  assign out_last_event = last_r;

  `KMCD_ASSERT_NOW(a_load_nonempty, cmd.load_out, diff_r != '0,
                   "event emitted from an empty change mask")
  `KMCD_ASSERT_NEXT(a_load_clears_one, cmd.load_out && !cmd.accept,
                    $countones(diff_r) == $countones($past(diff_r)) - 1,
                    "emit did not retire exactly one column")

endmodule

>>> bench/key_matrix_change_detector_core_tb.sv
module key_matrix_change_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmcd_pkg::*;

  // watchdog limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 600000;
  // settle time after the last event before a register write or the end
  localparam int SETTLE_CYCLES = 24;
  // counted row requests per random phase
  localparam int SCANS_PER_PHASE = 32;

  // one row request as it goes to the block
  typedef struct {
    logic [ROW_IDX_IN_W-1:0] row;
    logic [COL_FIELD_W-1:0]  levels;
  } row_scan_t;

  // one key event as the block should deliver it
  typedef struct {
    logic signed [EVENT_W-1:0] key_event;
    logic                      last_event;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ROW_IDX_IN_W-1:0]       in_row_index = '0;
  logic [COL_FIELD_W-1:0]        in_column_levels = '1;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [EVENT_W-1:0]     out_key_event;
  logic                          out_last_event;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = CFG_COLS_IN_USE;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  // pending row requests and the events they should produce
  row_scan_t  row_scans[$];
  row_scan_t  next_scan;
  key_event_t expected_events[$];

  // bench copy of the key levels and the two count registers
  logic [COL_FIELD_W-1:0] key_state[MAX_ROWS];
  logic [COL_CNT_W-1:0]   cols_reg = COL_CNT_W'(16);
  logic [ROW_CNT_W-1:0]   rows_reg = ROW_CNT_W'(8);

  // levels last queued per row, only used to shape the stimulus
  logic [COL_FIELD_W-1:0] queued_levels[MAX_ROWS];

  // idle rates in percent, set per phase
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int send_gap = 0;
  int stall_left = 0;

  int mismatches = 0;
  int cycles = 0;

  always #6 clk = ~clk;

  key_matrix_change_detector_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row_index     (in_row_index),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_key_event    (out_key_event),
    .out_last_event   (out_last_event),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // column count after saturation: zero acts as one, capped at the field width
  function automatic int cols_active();
    int n;
    n = cols_reg;
    if (n < 1) n = 1;
    if (n > EFF_COLS_MAX) n = EFF_COLS_MAX;
    return n;
  endfunction

  // row count after saturation: zero acts as one, capped at the row maximum
  function automatic int rows_active();
    int n;
    n = rows_reg;
    if (n < 1) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    return n;
  endfunction

  // compare one row sample with the stored levels and queue the key events
  task automatic scan_row(input logic [ROW_IDX_IN_W-1:0] row,
                          input logic [COL_FIELD_W-1:0] levels);
    int ncols;
    int num;
    logic [COL_FIELD_W-1:0] stored;
    key_event_t ev;
    bit changed;
    ncols = cols_active();
    changed = 1'b0;
    // rows outside the scanned range are dropped without a trace
    if (row >= rows_active()) return;
    stored = key_state[row];
    for (int c = 0; c < ncols; c++) begin
      if (levels[c] != stored[c]) begin
        num = row * ncols + c + 1;
        // low level is a press, high level a release
        ev.key_event = levels[c] ? EVENT_W'(-num) : EVENT_W'(num);
        ev.last_event = 1'b0;
        expected_events = {expected_events, ev};
        stored[c] = levels[c];
        changed = 1'b1;
      end
    end
    // columns beyond the count keep their old stored level
    key_state[row] = stored;
    if (changed) expected_events[expected_events.size()-1].last_event = 1'b1;
  endtask

  task automatic queue_row(input logic [ROW_IDX_IN_W-1:0] row,
                           input logic [COL_FIELD_W-1:0] levels);
    row_scan_t s;
    s.row = row;
    s.levels = levels;
    row_scans = {row_scans, s};
    queued_levels[row] = levels;
  endtask

  // single register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    // the write lands at this edge
    if (idx == CFG_COLS_IN_USE) cols_reg = data[COL_CNT_W-1:0];
    else rows_reg = data[ROW_CNT_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic set_counts(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows);
    write_reg(CFG_COLS_IN_USE, cols);
    write_reg(CFG_ROWS_IN_USE, rows);
  endtask

  // wait until every request went in and every event came out, then settle
  task automatic wait_drained();
    while (row_scans.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // row request driver with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // request taken at this edge: predict its events
      if (in_valid && !in_stall) scan_row(in_row_index, in_column_levels);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (row_scans.size() != 0) begin
          next_scan = row_scans.pop_front();
          in_valid <= 1'b1;
          in_row_index <= next_scan.row;
          in_column_levels <= next_scan.levels;
          if ($urandom_range(0, 99) < in_idle_pct) send_gap = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // event receiver stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < out_idle_pct) stall_left = $urandom_range(1, 17);
    end
  end

  // event monitor: each taken event against the oldest expected one
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual key_event %0d last %0b",
                 $time, out_key_event, out_last_event);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_key_event !== want.key_event) begin
          $display("%0t: key_event mismatch: expected %0d, actual %0d",
                   $time, want.key_event, out_key_event);
          mismatches++;
        end
        if (out_last_event !== want.last_event) begin
          $display("%0t: last_event mismatch: expected %0b, actual %0b",
                   $time, want.last_event, out_last_event);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events still expected", $time, expected_events.size());
      $display("** key_matrix_change_detector_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int used;
    int pick;
    logic [ROW_IDX_IN_W-1:0] r;
    logic [COL_FIELD_W-1:0] lv;

    for (int i = 0; i < MAX_ROWS; i++) begin
      key_state[i] = '1;
      queued_levels[i] = '1;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset counts: 16 columns, 8 rows
    in_idle_pct = 20;
    out_idle_pct = 20;
    queue_row(3'd0, 16'h0000);   // every key of the first row pressed
    queue_row(3'd0, 16'hFFFF);   // and released
    queue_row(3'd7, 16'h0000);   // top keys up to the largest number
    queue_row(3'd7, 16'hFFFF);
    queue_row(3'd3, 16'hAAAA);   // alternating presses
    queue_row(3'd3, 16'h5555);   // every key flips, mixed signs
    queue_row(3'd3, 16'hFFFF);
    queue_row(3'd5, 16'hFFFF);   // nothing changed, no event
    queue_row(3'd2, 16'h7FFE);   // outer columns only
    queue_row(3'd2, 16'hFFFF);
    wait_drained();

    // zero counts act as one column and one row
    set_counts(5'd0, 5'd0);
    queue_row(3'd0, 16'hFFFE);
    queue_row(3'd1, 16'h0000);   // row not in use
    queue_row(3'd7, 16'h0000);   // row not in use
    queue_row(3'd0, 16'h0001);   // upper columns not in use
    wait_drained();

    // oversized counts saturate to 16 columns and 8 rows
    set_counts(5'd31, 5'd15);
    queue_row(3'd7, 16'h0000);
    queue_row(3'd6, 16'h1234);
    queue_row(3'd7, 16'hFFFF);
    queue_row(3'd6, 16'hFFFF);
    wait_drained();

    // row count bit above the register width is dropped, leaving zero
    set_counts(5'd20, 5'd16);
    queue_row(3'd0, 16'h00FF);
    queue_row(3'd4, 16'h0000);
    queue_row(3'd0, 16'hFFFF);
    wait_drained();

    // narrow matrix, upper column bits ignored and kept
    set_counts(5'd5, 5'd3);
    queue_row(3'd2, 16'hFFE0);
    queue_row(3'd2, 16'h001F);
    queue_row(3'd3, 16'h0000);
    queue_row(3'd1, 16'h0000);
    queue_row(3'd1, 16'hFFFF);
    wait_drained();

    // random phases over several count settings, the last one without idling
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_counts(5'd16, 5'd8);
        1: set_counts(5'd1, 5'd1);
        2: set_counts(5'd0, 5'd0);
        3: set_counts(5'd31, 5'd15);
        4: set_counts(5'd7, 5'd5);
        5: set_counts(5'd16, 5'd1);
        6: set_counts(CFG_DATA_W'($urandom_range(0, 31)), CFG_DATA_W'($urandom_range(0, 31)));
        default: set_counts(5'd16, 5'd8);
      endcase
      if (p == 7) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct = $urandom_range(0, 3) * 20;
        out_idle_pct = $urandom_range(0, 3) * 20;
      end
      used = 0;
      while (used < SCANS_PER_PHASE) begin
        // mostly rows in use, some stray rows that must be dropped
        if ($urandom_range(0, 99) < 15) r = ROW_IDX_IN_W'($urandom_range(0, 7));
        else r = ROW_IDX_IN_W'($urandom_range(0, rows_active() - 1));
        pick = $urandom_range(0, 9);
        lv = queued_levels[r];
        case (pick)
          0: lv = '0;
          1: lv = '1;
          2, 3, 4: lv[$urandom_range(0, cols_active() - 1)] ^= 1'b1;
          5: begin
            lv[$urandom_range(0, 15)] ^= 1'b1;
            lv[$urandom_range(0, 15)] ^= 1'b1;
            lv[$urandom_range(0, 15)] ^= 1'b1;
          end
          default: lv = COL_FIELD_W'($urandom());
        endcase
        queue_row(r, lv);
        if (r < rows_active()) used++;
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("** key_matrix_change_detector_core: PASSED **");
    end else begin
      $display("** key_matrix_change_detector_core: FAILED **");
    end
    $finish;
  end

endmodule
